// ===== rtl/core/utf16be_stream_validator_core_assert.svh =====
// assertion macros for the validator checker
`ifndef UTF16BE_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define UTF16BE_STREAM_VALIDATOR_CORE_ASSERT_SVH

// check that is held off while reset is asserted
`define USV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("utf16be validator check failed");

// check that also looks at the cycles around reset
`define USV_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("utf16be validator reset check failed");

`endif

// ===== rtl/core/usv_pkg.sv =====
// types, constants and the gsm alphabet lookup for the utf16be validator
package usv_pkg;

  localparam logic [15:0] SURR_LO  = 16'hd800;
  localparam logic [15:0] SURR_MID = 16'hdc00;
  localparam logic [15:0] SURR_HI  = 16'hdfff;

  // gsm default alphabet lives on three unicode pages
  localparam logic [7:0] GSM_PAGE_LATIN  = 8'h00;
  localparam logic [7:0] GSM_PAGE_GREEK  = 8'h03;
  localparam logic [7:0] GSM_PAGE_SYMBOL = 8'h20;
  localparam logic [7:0] GSM_EURO_LO     = 8'hac;

  // depth of the queues between front, back and result port
  localparam int CLS_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRAIL = 2'd1,
    ERR_LEAD  = 2'd2
  } err_kind_t;

  // classified item handed from front to back
  typedef struct packed {
    logic term;
    logic lead;
    logic trail;
    logic gsm;
  } cls_t;

  // totals for one string
  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] unit_count;
    logic [15:0] symbol_count;
    logic [15:0] invalid_byte_count;
    err_kind_t   first_error_kind;
    logic [15:0] first_error_offset;
    logic        all_valid;
    logic        all_gsm;
  } res_t;

  function automatic logic in_gsm(input logic [15:0] u);
    logic [7:0] hi;
    logic [7:0] lo;
    logic       ok;
    hi = u[15:8];
    lo = u[7:0];
    ok = 1'b0;
    case (hi)
      GSM_PAGE_LATIN: begin
        case (lo) inside
          [8'h20:8'h5f], [8'h61:8'h7e], [8'ha3:8'ha5], [8'hc4:8'hc6], [8'he4:8'he9],
          8'h0a, 8'h0c, 8'h0d, 8'ha0, 8'ha1, 8'ha7, 8'hbf, 8'hc9, 8'hd1, 8'hd6,
          8'hd8, 8'hdc, 8'hdf, 8'he0, 8'hec, 8'hf1, 8'hf2, 8'hf6, 8'hf8, 8'hf9,
          8'hfc: ok = 1'b1;
          default: ok = 1'b0;
        endcase
      end
      GSM_PAGE_GREEK: begin
        case (lo) inside
          8'h93, 8'h94, 8'h98, 8'h9b, 8'h9e, 8'ha0, 8'ha3, 8'ha6, 8'ha8,
          8'ha9: ok = 1'b1;
          default: ok = 1'b0;
        endcase
      end
      GSM_PAGE_SYMBOL: ok = (lo == GSM_EURO_LO);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/core/usv_fifo.sv =====
// small register queue with count-based full and empty flags
module usv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  // flags
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/usv_front.sv =====
// front end: classifies each code unit before it is queued
module usv_front (
  input  logic [15:0]   code_unit,
  output usv_pkg::cls_t cls
);
  import usv_pkg::*;

  // surrogate ranges, terminator and gsm membership
  always_comb begin
    cls.term  = (code_unit == 16'h0000);
    cls.lead  = (code_unit >= SURR_LO) && (code_unit < SURR_MID);
    cls.trail = (code_unit >= SURR_MID) && (code_unit <= SURR_HI);
    cls.gsm   = in_gsm(code_unit);
  end

endmodule

// ===== rtl/core/usv_back.sv =====
// back end: surrogate pairing, saturating counters and first-error capture
module usv_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  usv_pkg::cls_t cls,
  input  logic          cls_empty,
  output logic          cls_pop,
  input  logic          res_full,
  output logic          res_push,
  output usv_pkg::res_t res
);
  import usv_pkg::*;

  logic                   lead_r, lead_nxt;
  logic [COUNT_WIDTH-1:0] bytes_r, bytes_nxt;
  logic [COUNT_WIDTH-1:0] units_r, units_nxt;
  logic [COUNT_WIDTH-1:0] syms_r, syms_nxt;
  logic [COUNT_WIDTH-1:0] bad_r, bad_nxt;
  err_kind_t              kind_r, kind_nxt;
  logic [COUNT_WIDTH-1:0] off_r, off_nxt;
  logic                   gsm_r, gsm_nxt;

  logic                   step;
  logic                   err_lead, err_trail, err_any, sym_inc;
  logic [COUNT_WIDTH-1:0] lead_off, bad_new, off_new;
  err_kind_t              kind_new;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [1:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + (COUNT_WIDTH + 1)'(b);
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [15:0] out16(input logic [COUNT_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_ffff) ? 16'hffff : w[15:0];
  endfunction

  // a terminator waits for room in the result queue
  assign step     = ~cls_empty & (~cls.term | ~res_full);
  assign cls_pop  = step;
  assign res_push = step & cls.term;

  // error detection and first-error capture
  always_comb begin
    err_lead  = lead_r & (cls.term | ~cls.trail);
    err_trail = ~cls.term & ~lead_r & cls.trail;
    err_any   = err_lead | err_trail;
    sym_inc   = (lead_r & cls.trail) | ~(cls.lead | cls.trail);
    lead_off  = (bytes_r >= COUNT_WIDTH'(2)) ? bytes_r - COUNT_WIDTH'(2) : '0;
    bad_new   = err_any ? sat_add(bad_r, 2'd2) : bad_r;
    kind_new  = kind_r;
    off_new   = off_r;
    if (err_any && kind_r == ERR_NONE) begin
      kind_new = err_lead ? ERR_LEAD : ERR_TRAIL;
      off_new  = err_lead ? lead_off : bytes_r;
    end
  end

  // next state of the per-string counters
  always_comb begin
    lead_nxt  = lead_r;
    bytes_nxt = bytes_r;
    units_nxt = units_r;
    syms_nxt  = syms_r;
    bad_nxt   = bad_r;
    kind_nxt  = kind_r;
    off_nxt   = off_r;
    gsm_nxt   = gsm_r;
    if (step) begin
      if (cls.term) begin
        lead_nxt  = 1'b0;
        bytes_nxt = '0;
        units_nxt = '0;
        syms_nxt  = '0;
        bad_nxt   = '0;
        kind_nxt  = ERR_NONE;
        off_nxt   = '0;
        gsm_nxt   = 1'b1;
      end else begin
        lead_nxt  = cls.lead;
        bytes_nxt = sat_add(bytes_r, 2'd2);
        units_nxt = sat_add(units_r, 2'd1);
        syms_nxt  = sym_inc ? sat_add(syms_r, 2'd1) : syms_r;
        bad_nxt   = bad_new;
        kind_nxt  = kind_new;
        off_nxt   = off_new;
        gsm_nxt   = gsm_r & cls.gsm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 1'b0;
      bytes_r <= '0;
      units_r <= '0;
      syms_r  <= '0;
      bad_r   <= '0;
      kind_r  <= ERR_NONE;
      off_r   <= '0;
      gsm_r   <= 1'b1;
    end else begin
      lead_r  <= lead_nxt;
      bytes_r <= bytes_nxt;
      units_r <= units_nxt;
      syms_r  <= syms_nxt;
      bad_r   <= bad_nxt;
      kind_r  <= kind_nxt;
      off_r   <= off_nxt;
      gsm_r   <= gsm_nxt;
    end
  end

  // totals for the string, including an unpaired lead at the terminator
  always_comb begin
    res.byte_count         = out16(bytes_r);
    res.unit_count         = out16(units_r);
    res.symbol_count       = out16(syms_r);
    res.invalid_byte_count = out16(bad_new);
    res.first_error_kind   = kind_new;
    res.first_error_offset = out16(off_new);
    res.all_valid          = (bad_new == '0);
    res.all_gsm            = gsm_r;
  end

endmodule

// ===== rtl/core/utf16be_stream_validator_core.sv =====
// UTF-16BE stream validator: takes one code unit per cycle, with no bubbles
// between strings while results are taken. Each item is classified (surrogate
// kind, GSM 03.38 membership) and written to a two-entry queue; the back end
// drains it at one item per cycle unless a terminator waits for room, updating
// saturating counters of COUNT_WIDTH bits. A zero unit ends the string: its
// totals are queued as the terminator is taken, and the state is reset. Results
// wait in a two-entry queue, so in_full rises only when two results sit untaken
// and a third terminator reaches the back end. Other units give no result.
module utf16be_stream_validator_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_code_unit,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_byte_count,
  output logic [15:0] out_unit_count,
  output logic [15:0] out_symbol_count,
  output logic [15:0] out_invalid_byte_count,
  output logic [1:0]  out_first_error_kind,
  output logic [15:0] out_first_error_offset,
  output logic        out_all_valid,
  output logic        out_all_gsm
);
  import usv_pkg::*;

  cls_t cls_in, cls_q;
  logic cls_empty, cls_pop;
  res_t res_d, res_q;
  logic res_full, res_push;

  // classify at the input
  usv_front u_front (
    .code_unit (in_code_unit),
    .cls       (cls_in)
  );

  // queue between front and back
  usv_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (CLS_Q_DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls_in),
    .full  (in_full),
    .pop   (cls_pop),
    .rdata (cls_q),
    .empty (cls_empty)
  );

  // counting and error tracking
  usv_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls       (cls_q),
    .cls_empty (cls_empty),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_d)
  );

  // result queue
  usv_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_d),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty)
  );

  // result fields
  assign out_byte_count         = res_q.byte_count;
  assign out_unit_count         = res_q.unit_count;
  assign out_symbol_count       = res_q.symbol_count;
  assign out_invalid_byte_count = res_q.invalid_byte_count;
  assign out_first_error_kind   = res_q.first_error_kind;
  assign out_first_error_offset = res_q.first_error_offset;
  assign out_all_valid          = res_q.all_valid;
  assign out_all_gsm            = res_q.all_gsm;

endmodule

// ===== rtl/core/usv_checker.sv =====
// port-level checks for the validator, bound to the top level
`include "utf16be_stream_validator_core_assert.svh"

module usv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic [15:0] out_invalid_byte_count,
  input logic [1:0]  out_first_error_kind,
  input logic [15:0] out_first_error_offset,
  input logic        out_all_valid
);
  import usv_pkg::*;

  // the result queue comes out of reset empty and the input queue not full
  `USV_ASSERT_RST(a_empty_after_rst, $past(!rst_n) |-> (out_empty && !in_full))

  // all_valid agrees with the invalid byte total
  `USV_ASSERT(a_valid_matches, !out_empty |-> (out_all_valid == (out_invalid_byte_count == 16'd0)))

  // an error kind is recorded exactly when invalid bytes were counted
  `USV_ASSERT(a_kind_matches, !out_empty |-> ((out_first_error_kind == ERR_NONE) == out_all_valid))

  // no error means offset zero
  `USV_ASSERT(a_off_zero, (!out_empty && out_first_error_kind == ERR_NONE) |-> (out_first_error_offset == 16'd0))

endmodule

bind utf16be_stream_validator_core usv_checker u_usv_checker (.*);
